// ----- rtl/wpvg_pkg.sv -----
// Shared types, widths and constants for the waypoint PD velocity guidance block.
package wpvg_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned TOL_W   = 12;
  localparam int unsigned DWELL_W = 8;
  localparam int unsigned LEG_W   = 3;
  localparam int unsigned CIDX_W  = 3;

  localparam int unsigned ERR_W   = POS_W + 1;
  localparam int unsigned DIFF_W  = POS_W + 2;
  localparam int unsigned PRODP_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned PRODD_W = GAIN_W + 1 + DIFF_W;
  localparam int unsigned ACC_W   = PRODD_W + 1;

  localparam logic [GAIN_W-1:0]        KP_RST    = GAIN_W'(4096);
  localparam logic [GAIN_W-1:0]        KD_RST    = GAIN_W'(7700);
  localparam logic [TOL_W-1:0]         TOL_RST   = TOL_W'(205);
  localparam logic [DWELL_W-1:0]       DWELL_RST = DWELL_W'(40);
  localparam logic signed [POS_W-1:0]  ALT_RST   = POS_W'(8192);
  localparam logic signed [POS_W-1:0]  LEGX_RST  = POS_W'(81920);
  localparam logic signed [POS_W-1:0]  LEGY_RST  = POS_W'(81920);

  typedef enum logic [LEG_W-1:0] {
    LEG_TAKEOFF = 3'd0,
    LEG_OUT_X   = 3'd1,
    LEG_OUT_Y   = 3'd2,
    LEG_BACK_X  = 3'd3,
    LEG_HOME    = 3'd4,
    LEG_LAND    = 3'd5,
    LEG_DONE    = 3'd6
  } leg_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_KP    = 3'd0,
    CFG_KD    = 3'd1,
    CFG_TOL   = 3'd2,
    CFG_DWELL = 3'd3,
    CFG_ALT   = 3'd4,
    CFG_LEGX  = 3'd5,
    CFG_LEGY  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]       kp_gain;
    logic [GAIN_W-1:0]       kd_gain;
    logic [TOL_W-1:0]        arrive_tol;
    logic [DWELL_W-1:0]      dwell_ticks;
    logic signed [POS_W-1:0] hover_alt;
    logic signed [POS_W-1:0] leg_x;
    logic signed [POS_W-1:0] leg_y;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] meas_x;
    logic signed [POS_W-1:0] meas_y;
    logic signed [POS_W-1:0] meas_z;
    logic                    engaged;
  } in_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic signed [POS_W-1:0] vel_z;
    logic [LEG_W-1:0]        leg_index;
    logic                    land_request;
  } out_rsp_t;

  // Per-request control that travels down the pipeline beside the lanes
  typedef struct packed {
    logic             pd;
    logic             land;
    logic [LEG_W-1:0] leg;
  } seq_ctl_t;

endpackage

// ----- rtl/waypoint_pd_velocity_guidance_top.sv -----
// Top level of the waypoint PD velocity guidance block.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_req_i) carries one position
//   sample per request: meas_x/y/z in Q12.12 metres and the engaged flag.
//   Output channel (out_valid_o/out_ready_i/out_rsp_o) returns one request
//   per sample: saturated x/y/z velocity, the leg after the sample and a
//   one-sample land request when leg five is reached.
//   Config port (cfg_we_i/cfg_idx_i/cfg_wdata_i) writes gains, arrival window,
//   dwell count, altitude and rectangle extents; write only while idle.
// Timing:
//   Three PD lanes (x, y, z) run side by side; the leg sequencer updates its
//   state in the accept cycle, then error/difference, gain products and the
//   round/clamp/merge stage follow, ending in the output register that drives
//   out_valid_o; throughput is one request per cycle, as every stage is
//   registered and all stages hold together only on an output stall.
// Reset: gains and targets return to defaults, leg 0, dwell and previous
//   errors cleared, held velocities zero, pipeline empty.
// Stall: while a result waits on out_ready_i the whole pipeline holds and
//   in_ready_o drops; nothing is dropped or repeated.
module waypoint_pd_velocity_guidance_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wpvg_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wpvg_pkg::out_rsp_t                  out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [wpvg_pkg::CIDX_W-1:0]         cfg_idx_i,
  input  logic [wpvg_pkg::POS_W-1:0]          cfg_wdata_i
);

  localparam int unsigned POS_W   = wpvg_pkg::POS_W;
  localparam int unsigned GAIN_W  = wpvg_pkg::GAIN_W;
  localparam int unsigned TOL_W   = wpvg_pkg::TOL_W;
  localparam int unsigned DWELL_W = wpvg_pkg::DWELL_W;

  wpvg_pkg::cfg_t      cfg_q;
  wpvg_pkg::seq_ctl_t  ctl, ctl1_q, ctl2_q;
  wpvg_pkg::out_rsp_t  out_q;
  logic                adv, acc, upd;
  logic                v1_q, v2_q, vo_q;
  logic signed [POS_W-1:0] tgt_x, tgt_y, tgt_z;
  logic signed [POS_W-1:0] vel_x, vel_y, vel_z;
  logic signed [POS_W-1:0] held_x_q, held_y_q, held_z_q;
  logic signed [POS_W-1:0] sel_x, sel_y, sel_z;

  // Global stall: every stage moves only when the output slot frees up
  assign adv        = !vo_q || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain     <= wpvg_pkg::KP_RST;
      cfg_q.kd_gain     <= wpvg_pkg::KD_RST;
      cfg_q.arrive_tol  <= wpvg_pkg::TOL_RST;
      cfg_q.dwell_ticks <= wpvg_pkg::DWELL_RST;
      cfg_q.hover_alt   <= wpvg_pkg::ALT_RST;
      cfg_q.leg_x       <= wpvg_pkg::LEGX_RST;
      cfg_q.leg_y       <= wpvg_pkg::LEGY_RST;
    end else if (cfg_we_i) begin
      case (wpvg_pkg::cfg_idx_e'(cfg_idx_i))
        wpvg_pkg::CFG_KP:    cfg_q.kp_gain     <= cfg_wdata_i[GAIN_W-1:0];
        wpvg_pkg::CFG_KD:    cfg_q.kd_gain     <= cfg_wdata_i[GAIN_W-1:0];
        wpvg_pkg::CFG_TOL:   cfg_q.arrive_tol  <= cfg_wdata_i[TOL_W-1:0];
        wpvg_pkg::CFG_DWELL: cfg_q.dwell_ticks <= cfg_wdata_i[DWELL_W-1:0];
        wpvg_pkg::CFG_ALT:   cfg_q.hover_alt   <= cfg_wdata_i;
        wpvg_pkg::CFG_LEGX:  cfg_q.leg_x       <= cfg_wdata_i;
        wpvg_pkg::CFG_LEGY:  cfg_q.leg_y       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  wpvg_leg_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .req_i   (in_req_i),
    .cfg_i   (cfg_q),
    .tgt_x_o (tgt_x),
    .tgt_y_o (tgt_y),
    .tgt_z_o (tgt_z),
    .upd_o   (upd),
    .ctl_o   (ctl)
  );

  wpvg_pd_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .upd_i    (upd),
    .target_i (tgt_x),
    .meas_i   (in_req_i.meas_x),
    .kp_i     (cfg_q.kp_gain),
    .kd_i     (cfg_q.kd_gain),
    .vel_o    (vel_x)
  );

  wpvg_pd_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .upd_i    (upd),
    .target_i (tgt_y),
    .meas_i   (in_req_i.meas_y),
    .kp_i     (cfg_q.kp_gain),
    .kd_i     (cfg_q.kd_gain),
    .vel_o    (vel_y)
  );

  wpvg_pd_lane u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .upd_i    (upd),
    .target_i (tgt_z),
    .meas_i   (in_req_i.meas_z),
    .kp_i     (cfg_q.kp_gain),
    .kd_i     (cfg_q.kd_gain),
    .vel_o    (vel_z)
  );

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  // Control travelling beside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl1_q <= ctl;
      ctl2_q <= ctl1_q;
    end
  end

  // Merge: fresh lane results on PD samples, otherwise the held velocities
  assign sel_x = ctl2_q.pd ? vel_x : held_x_q;
  assign sel_y = ctl2_q.pd ? vel_y : held_y_q;
  assign sel_z = ctl2_q.pd ? vel_z : held_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_y_q <= '0;
      held_z_q <= '0;
    end else if (adv && v2_q) begin
      held_x_q <= sel_x;
      held_y_q <= sel_y;
      held_z_q <= sel_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      out_q.vel_x        <= sel_x;
      out_q.vel_y        <= sel_y;
      out_q.vel_z        <= sel_z;
      out_q.leg_index    <= ctl2_q.leg;
      out_q.land_request <= ctl2_q.land;
    end
  end

  assign out_valid_o = vo_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- rtl/wpvg_pd_lane.sv -----
// One axis PD lane: error, derivative, gain products, rounding and saturation.
module wpvg_pd_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 upd_i,
  input  logic signed [wpvg_pkg::POS_W-1:0]    target_i,
  input  logic signed [wpvg_pkg::POS_W-1:0]    meas_i,
  input  logic [wpvg_pkg::GAIN_W-1:0]          kp_i,
  input  logic [wpvg_pkg::GAIN_W-1:0]          kd_i,
  output logic signed [wpvg_pkg::POS_W-1:0]    vel_o
);

  localparam int unsigned POS_W   = wpvg_pkg::POS_W;
  localparam int unsigned ERR_W   = wpvg_pkg::ERR_W;
  localparam int unsigned DIFF_W  = wpvg_pkg::DIFF_W;
  localparam int unsigned GAIN_W  = wpvg_pkg::GAIN_W;
  localparam int unsigned PRODP_W = wpvg_pkg::PRODP_W;
  localparam int unsigned PRODD_W = wpvg_pkg::PRODD_W;
  localparam int unsigned ACC_W   = wpvg_pkg::ACC_W;
  localparam int unsigned FRAC_W  = wpvg_pkg::FRAC_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_W - 1);

  logic signed [ERR_W-1:0]   prev_q;
  logic signed [ERR_W-1:0]   err_d, err_q;
  logic signed [DIFF_W-1:0]  diff_d, diff_q;
  logic signed [PRODP_W-1:0] prodp_d, prodp_q;
  logic signed [PRODD_W-1:0] prodd_d, prodd_q;
  logic signed [GAIN_W:0]    kp_s, kd_s;
  logic signed [ACC_W-1:0]   acc, shifted;
  logic                      fits;

  assign err_d  = ERR_W'(target_i) - ERR_W'(meas_i);
  assign diff_d = DIFF_W'(err_d) - DIFF_W'(prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (upd_i) begin
      prev_q <= err_d;
    end
  end

  // stage 1: error and difference
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
  end

  assign kp_s    = signed'({1'b0, kp_i});
  assign kd_s    = signed'({1'b0, kd_i});
  assign prodp_d = PRODP_W'(kp_s) * PRODP_W'(err_q);
  assign prodd_d = PRODD_W'(kd_s) * PRODD_W'(diff_q);

  // stage 2: gain products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prodp_q <= prodp_d;
      prodd_q <= prodd_d;
    end
  end

  // round to nearest, ties up, then clamp to the position range
  assign acc     = ACC_W'(prodp_q) + ACC_W'(prodd_q) + HALF;
  assign shifted = acc >>> FRAC_W;
  assign fits    = (shifted[ACC_W-1:POS_W-1] == '0) || (shifted[ACC_W-1:POS_W-1] == '1);

  always_comb begin
    if (fits) begin
      vel_o = shifted[POS_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      vel_o = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      vel_o = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/wpvg_leg_seq.sv -----
// Leg sequencer: leg targets, arrival window, dwell count and land request.
module wpvg_leg_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  wpvg_pkg::in_req_t                 req_i,
  input  wpvg_pkg::cfg_t                    cfg_i,
  output logic signed [wpvg_pkg::POS_W-1:0] tgt_x_o,
  output logic signed [wpvg_pkg::POS_W-1:0] tgt_y_o,
  output logic signed [wpvg_pkg::POS_W-1:0] tgt_z_o,
  output logic                              upd_o,
  output wpvg_pkg::seq_ctl_t                ctl_o
);

  localparam int unsigned POS_W   = wpvg_pkg::POS_W;
  localparam int unsigned DIFF_W  = wpvg_pkg::DIFF_W;
  localparam int unsigned DWELL_W = wpvg_pkg::DWELL_W;

  wpvg_pkg::leg_e          leg_q, leg_d;
  logic [DWELL_W-1:0]      dwell_q, dwell_d;
  logic signed [POS_W-1:0] chk_m, chk_t;
  logic signed [DIFF_W-1:0] tol_s, win_lo, win_hi, chk_w;
  logic                    pd, in_win, land;

  always_comb begin
    tgt_x_o = '0;
    tgt_y_o = '0;
    chk_m   = req_i.meas_y;
    chk_t   = '0;
    case (leg_q)
      wpvg_pkg::LEG_OUT_X:  tgt_x_o = cfg_i.leg_x;
      wpvg_pkg::LEG_OUT_Y: begin
        tgt_x_o = cfg_i.leg_x;
        tgt_y_o = cfg_i.leg_y;
      end
      wpvg_pkg::LEG_BACK_X: tgt_y_o = cfg_i.leg_y;
      default: ;
    endcase
    tgt_z_o = cfg_i.hover_alt;
    // axis that decides arrival on each leg
    case (leg_q)
      wpvg_pkg::LEG_TAKEOFF: begin
        chk_m = req_i.meas_z;
        chk_t = tgt_z_o;
      end
      wpvg_pkg::LEG_OUT_X, wpvg_pkg::LEG_BACK_X: begin
        chk_m = req_i.meas_x;
        chk_t = tgt_x_o;
      end
      default: begin
        chk_m = req_i.meas_y;
        chk_t = tgt_y_o;
      end
    endcase
  end

  assign tol_s  = signed'(DIFF_W'(cfg_i.arrive_tol));
  assign win_lo = DIFF_W'(chk_t) - tol_s;
  assign win_hi = DIFF_W'(chk_t) + tol_s;
  assign chk_w  = DIFF_W'(chk_m);
  assign in_win = (chk_w > win_lo) && (chk_w < win_hi);

  assign pd = req_i.engaged && (leg_q <= wpvg_pkg::LEG_HOME);

  always_comb begin
    leg_d   = leg_q;
    dwell_d = dwell_q;
    land    = 1'b0;
    if (pd) begin
      if (in_win) begin
        if (dwell_q >= cfg_i.dwell_ticks) begin
          leg_d   = wpvg_pkg::leg_e'(leg_q + 3'd1);
          dwell_d = '0;
        end else begin
          dwell_d = dwell_q + DWELL_W'(1);
        end
      end else begin
        dwell_d = '0;
      end
    end else if (req_i.engaged && (leg_q == wpvg_pkg::LEG_LAND)) begin
      leg_d = wpvg_pkg::LEG_DONE;
      land  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_q   <= wpvg_pkg::LEG_TAKEOFF;
      dwell_q <= '0;
    end else if (acc_i) begin
      leg_q   <= leg_d;
      dwell_q <= dwell_d;
    end
  end

  assign upd_o     = acc_i && pd;
  assign ctl_o.pd   = pd;
  assign ctl_o.land = land;
  assign ctl_o.leg  = leg_d;

endmodule
